### src/rhsl_pkg.sv
// ----------------------------------------------------------------------------
// rhsl_pkg: shared definitions for the rgb to hsl converter
// Default sizes, scale constants, lane indexes and the control word that
// travels down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
package rhsl_pkg;
	localparam int COMPONENT_BITS_DEF = 8;
	// quotient bits per ratio, enough for a hue of 360
	localparam int QUO_BITS = 9;
	localparam int HUE_SECTOR = 60;
	localparam int HUE_FULL = 360;
	localparam int PCT_SCALE = 100;

	// lane indexes of the three ratios
	localparam int LANE_HUE = 0;
	localparam int LANE_SAT = 1;
	localparam int LANE_LIGHT = 2;
	localparam int LANES = 3;

	typedef struct packed {
		logic valid;
		logic grey;
	} rhsl_ctl_t;
endpackage
`default_nettype wire

### src/rhsl_prep.sv
// ----------------------------------------------------------------------------
// rhsl_prep: front cell of the converter
// Finds max, min, delta and sum and forms a rounded numerator and a
// denominator for each of hue, saturation and lightness.
// ----------------------------------------------------------------------------
`default_nettype none
module rhsl_prep #(
	parameter int CB = 8,
	parameter int NW = 18,
	parameter int DW = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic [CB-1:0]                red,
	input  wire logic [CB-1:0]                green,
	input  wire logic [CB-1:0]                blue,
	output rhsl_pkg::rhsl_ctl_t               ctl_s1,
	output logic [rhsl_pkg::LANES-1:0][NW-1:0] num_s1,
	output logic [rhsl_pkg::LANES-1:0][DW-1:0] den_s1
);
	import rhsl_pkg::*;

	localparam logic [NW-1:0] FULL = NW'((64'd1 << CB) - 64'd1);
	localparam logic [NW-1:0] SIXTY = NW'(HUE_SECTOR);
	localparam logic [NW-1:0] PCT2 = NW'(2 * PCT_SCALE);

	logic [NW-1:0] rw, gw, bw, mx, mn, delta, sum, hnum, den_sat;
	logic [LANES-1:0][NW-1:0] num_d;
	logic [LANES-1:0][DW-1:0] den_d;

	always_comb begin
		rw = NW'(red);
		gw = NW'(green);
		bw = NW'(blue);
		mx = rw;
		mn = rw;
		if (gw > mx) mx = gw;
		if (bw > mx) mx = bw;
		if (gw < mn) mn = gw;
		if (bw < mn) mn = bw;
		delta = mx - mn;
		sum = mx + mn;
		// sector rule, red wins ties, then green
		if (mx == rw) begin
			if (gw >= bw) hnum = SIXTY * (gw - bw);
			else hnum = NW'(6) * SIXTY * delta - SIXTY * (bw - gw);
		end else if (mx == gw) begin
			if (bw >= rw) hnum = NW'(2) * SIXTY * delta + SIXTY * (bw - rw);
			else hnum = NW'(2) * SIXTY * delta - SIXTY * (rw - bw);
		end else begin
			if (rw >= gw) hnum = NW'(4) * SIXTY * delta + SIXTY * (rw - gw);
			else hnum = NW'(4) * SIXTY * delta - SIXTY * (gw - rw);
		end
		den_sat = (sum < FULL) ? sum : (FULL + FULL - sum);
		// round(n/d) = floor((2n + d) / 2d)
		num_d[LANE_HUE] = (hnum << 1) + delta;
		num_d[LANE_SAT] = PCT2 * delta + den_sat;
		num_d[LANE_LIGHT] = PCT2 * sum + FULL + FULL;
		den_d[LANE_HUE] = DW'(delta << 1);
		den_d[LANE_SAT] = DW'(den_sat << 1);
		den_d[LANE_LIGHT] = DW'(FULL << 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.grey <= (delta == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= num_d;
			den_s1 <= den_d;
		end
	end
endmodule
`default_nettype wire

### src/rhsl_div_cell.sv
// ----------------------------------------------------------------------------
// rhsl_div_cell: one restoring division step for all three lanes
// Settles quotient bit BIT of each ratio and hands the remainder on.
// ----------------------------------------------------------------------------
`default_nettype none
module rhsl_div_cell #(
	parameter int NW = 18,
	parameter int DW = 10,
	parameter int QW = 9,
	parameter int BIT = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire rhsl_pkg::rhsl_ctl_t           ctl_i,
	input  wire logic [rhsl_pkg::LANES-1:0][NW-1:0] rem_i,
	input  wire logic [rhsl_pkg::LANES-1:0][DW-1:0] den_i,
	input  wire logic [rhsl_pkg::LANES-1:0][QW-1:0] quo_i,
	output rhsl_pkg::rhsl_ctl_t                ctl_q,
	output logic [rhsl_pkg::LANES-1:0][NW-1:0] rem_q,
	output logic [rhsl_pkg::LANES-1:0][DW-1:0] den_q,
	output logic [rhsl_pkg::LANES-1:0][QW-1:0] quo_q
);
	import rhsl_pkg::*;

	logic [LANES-1:0][NW:0] diff;
	logic [LANES-1:0][NW-1:0] rem_d;
	logic [LANES-1:0][QW-1:0] quo_d;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			diff[l] = {1'b0, rem_i[l]} - ((NW+1)'(den_i[l]) << BIT);
			rem_d[l] = diff[l][NW] ? rem_i[l] : diff[l][NW-1:0];
			quo_d[l] = quo_i[l];
			quo_d[l][BIT] = !diff[l][NW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_d;
			den_q <= den_i;
			quo_q <= quo_d;
		end
	end
endmodule
`default_nettype wire

### src/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter: pixel rgb to integer hsl
// Front cell, a row of division cells and an output register.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns hue in degrees (0..359), saturation
// and lightness in percent (0..100), each rounded half up. The chain is
// one front cell, one division cell per quotient bit, and the output
// register. A stall on the output holds the whole chain; otherwise one
// transaction is taken every cycle.
`default_nettype none
module rgb_to_hsl_converter #(
	parameter int COMPONENT_BITS = rhsl_pkg::COMPONENT_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [COMPONENT_BITS-1:0] red,
	input  wire logic [COMPONENT_BITS-1:0] green,
	input  wire logic [COMPONENT_BITS-1:0] blue,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [8:0]                     hue,
	output logic [6:0]                     saturation,
	output logic [6:0]                     lightness
);
	import rhsl_pkg::*;

	localparam int NW = COMPONENT_BITS + 10;
	localparam int DW = COMPONENT_BITS + 2;
	localparam int QW = QUO_BITS;

	logic en;
	rhsl_ctl_t ctl_c [QW+1];
	logic [LANES-1:0][NW-1:0] rem_c [QW+1];
	logic [LANES-1:0][DW-1:0] den_c [QW+1];
	logic [LANES-1:0][QW-1:0] quo_c [QW+1];
	logic valid_q;
	logic [8:0] hue_q;
	logic [6:0] sat_q, light_q;
	logic [QW-1:0] hq, sq, lq;

	assign en = !valid_q || out_ready;
	assign in_ready = en;

	rhsl_prep #(.CB(COMPONENT_BITS), .NW(NW), .DW(DW)) u_prep (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.red(red), .green(green), .blue(blue),
		.ctl_s1(ctl_c[0]), .num_s1(rem_c[0]), .den_s1(den_c[0])
	);
	assign quo_c[0] = '0;

	for (genvar k = 0; k < QW; k++) begin : g_cell
		rhsl_div_cell #(.NW(NW), .DW(DW), .QW(QW), .BIT(QW-1-k)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.ctl_i(ctl_c[k]), .rem_i(rem_c[k]), .den_i(den_c[k]), .quo_i(quo_c[k]),
			.ctl_q(ctl_c[k+1]), .rem_q(rem_c[k+1]), .den_q(den_c[k+1]),
			.quo_q(quo_c[k+1])
		);
	end

	assign hq = quo_c[QW][LANE_HUE];
	assign sq = quo_c[QW][LANE_SAT];
	assign lq = quo_c[QW][LANE_LIGHT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_c[QW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// grey pixel: hue and saturation forced to zero
			if (ctl_c[QW].grey) begin
				hue_q <= '0;
				sat_q <= '0;
			end else begin
				hue_q <= (hq >= QW'(HUE_FULL)) ? 9'(hq - QW'(HUE_FULL)) : 9'(hq);
				sat_q <= (sq > QW'(PCT_SCALE)) ? 7'(PCT_SCALE) : 7'(sq);
			end
			light_q <= (lq > QW'(PCT_SCALE)) ? 7'(PCT_SCALE) : 7'(lq);
		end
	end

	assign out_valid = valid_q;
	assign hue = hue_q;
	assign saturation = sat_q;
	assign lightness = light_q;
endmodule
`default_nettype wire

### src/rhsl_checker.sv
// ----------------------------------------------------------------------------
// rhsl_checker: port checks for the rgb to hsl converter
// Range of results and hold of a stalled transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module rhsl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [8:0] hue,
	input wire logic [6:0] saturation,
	input wire logic [6:0] lightness
);
	import rhsl_pkg::*;

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hue < 9'(HUE_FULL)))
		else $error("hue out of range");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (saturation <= 7'(PCT_SCALE) && lightness <= 7'(PCT_SCALE)))
		else $error("percent out of range");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while output stalled");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(hue)
			&& $stable(saturation) && $stable(lightness)))
		else $error("stalled result changed");
endmodule

bind rgb_to_hsl_converter rhsl_checker u_rhsl_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .hue(hue), .saturation(saturation), .lightness(lightness)
);
`default_nettype wire

### dv/rgb_to_hsl_checker.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_checker: scoreboard for the rgb to hsl converter
// Watches both channels, predicts hue, saturation and lightness for every
// accepted pixel and compares each output transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none
module rgb_to_hsl_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [8:0] hue,
	input  wire logic [6:0] saturation,
	input  wire logic [6:0] lightness,
	output int              fail_count,
	output int              pending
);
	import rhsl_pkg::*;

	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] sat;
		logic [6:0] light;
	} hsl_t;

	localparam int FULL = 255;

	hsl_t hsl_queue[$];

	function automatic int unsigned round_half_up(int unsigned num, int unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic hsl_t rgb_to_hsl(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
		int unsigned r, g, b, mx, mn, delta, sum, den, hnum, h, s, l;
		hsl_t res;
		r = r8;
		g = g8;
		b = b8;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		sum = mx + mn;
		h = 0;
		s = 0;
		l = round_half_up(PCT_SCALE * sum, 2 * FULL);
		if (l > PCT_SCALE) l = PCT_SCALE;
		if (delta != 0) begin
			den = (sum < FULL) ? sum : (2 * FULL - sum);
			s = round_half_up(PCT_SCALE * delta, den);
			if (s > PCT_SCALE) s = PCT_SCALE;
			// sector rule, red wins ties, then green
			if (mx == r)
				hnum = (g >= b) ? HUE_SECTOR * (g - b)
					: HUE_FULL * delta - HUE_SECTOR * (b - g);
			else if (mx == g)
				hnum = (b >= r) ? 120 * delta + HUE_SECTOR * (b - r)
					: 120 * delta - HUE_SECTOR * (r - b);
			else
				hnum = (r >= g) ? 240 * delta + HUE_SECTOR * (r - g)
					: 240 * delta - HUE_SECTOR * (g - r);
			h = round_half_up(hnum, delta) % HUE_FULL;
		end
		res.hue = h[8:0];
		res.sat = s[6:0];
		res.light = l[6:0];
		return res;
	endfunction

	assign pending = hsl_queue.size();

	always @(posedge clk or negedge arst_n) begin
		hsl_t exp_hsl;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready)
				hsl_queue.push_back(rgb_to_hsl(red, green, blue));
			if (out_valid && out_ready) begin
				if (hsl_queue.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected transaction: h=%0d s=%0d l=%0d",
							hue, saturation, lightness);
				end else begin
					exp_hsl = hsl_queue.pop_front();
					if (exp_hsl.hue !== hue || exp_hsl.sat !== saturation
						|| exp_hsl.light !== lightness) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected h=%0d s=%0d l=%0d, got h=%0d s=%0d l=%0d",
								exp_hsl.hue, exp_hsl.sat, exp_hsl.light,
								hue, saturation, lightness);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

### dv/tb_rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsl_converter: testbench top for the rgb to hsl converter
// Directed corner pixels then random pixels with random gaps on both sides;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rgb_to_hsl_converter;
	localparam int N_RANDOM = 500;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [8:0] hue;
	logic [6:0] saturation;
	logic [6:0] lightness;
	int         fail_count;
	int         pending;
	int         idle_cycles = 0;
	int         rx_wait = 0;

	always #5 clk = ~clk;

	rgb_to_hsl_converter u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.hue(hue), .saturation(saturation), .lightness(lightness)
	);

	rgb_to_hsl_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.hue(hue), .saturation(saturation), .lightness(lightness),
		.fail_count(fail_count), .pending(pending)
	);

	// gap draw: often none, so back-to-back stretches occur
	function automatic int draw_gap();
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
	endfunction

	// valid stays high across back-to-back transactions
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		red <= r;
		green <= g;
		blue <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// directed: greys, primaries, ties, negative red sector, wrap to zero
	task automatic send_directed();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd200, 8'd10, 8'd50);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd127, 8'd128, 8'd127);
		send_pixel(8'd128, 8'd127, 8'd127);
		send_pixel(8'd100, 8'd50, 8'd100);
		send_pixel(8'd170, 8'd85, 8'd0);
	endtask

	// receiver waits a drawn number of cycles before each transaction
	always @(posedge clk) begin
		int nxt;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= draw_gap();
		end else if (out_valid && out_ready) begin
			nxt = draw_gap();
			rx_wait <= nxt;
			out_ready <= (nxt == 0);
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			out_ready <= (rx_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** rgb_to_hsl_converter: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [7:0] grey_lvl;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		for (int i = 0; i < N_RANDOM; i++) begin
			// hold off once mid run until the pipe drains
			if (i == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			case ($urandom_range(0, 4))
				0: begin
					grey_lvl = 8'($urandom_range(0, 255));
					send_pixel(grey_lvl, grey_lvl, grey_lvl);
				end
				1: send_pixel(8'd255, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				default: send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			endcase
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** rgb_to_hsl_converter: PASSED **");
		else
			$display("** rgb_to_hsl_converter: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
